/* design/qrs_pkg.sv */
`default_nettype none
package qrs_pkg;

	localparam int COEF_WIDTH = 24;
	localparam int FRAC_BITS  = 12;
	localparam int ROOT_WIDTH = 40;

	// Discriminant: signed width, and width of its magnitude.
	localparam int D_W   = 2 * COEF_WIDTH + 3;
	localparam int DM_W  = 2 * COEF_WIDTH + 1;
	// Square root of |D| scaled by 2^(2*FRAC_BITS).
	localparam int SQ_W  = (DM_W + 2 * FRAC_BITS + 1) / 2;
	localparam int RAD_W = 2 * SQ_W;
	localparam int RM_W  = SQ_W + 2;
	// Numerators of the divisions by 2a.
	localparam int NB_W  = COEF_WIDTH + FRAC_BITS + 1;
	localparam int NUM_W = ((NB_W > SQ_W + 1) ? NB_W : SQ_W + 1) + 1;
	localparam int DEN_W = COEF_WIDTH + 1;
	localparam int DR_W  = DEN_W + 1;
	localparam int DIV_LAT = NUM_W + 1;
	localparam int QS_W  = NUM_W + 1;
	localparam int EXT_W = ((QS_W > ROOT_WIDTH) ? QS_W : ROOT_WIDTH) + 1;

	localparam int IN_DATA_W  = ((3 * COEF_WIDTH + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((3 * ROOT_WIDTH + 7) / 8) * 8;
	localparam int OUT_USER_W = 4;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] KIND_TWO_REAL = 2'd0;
	localparam logic [1:0] KIND_DOUBLE   = 2'd1;
	localparam logic [1:0] KIND_COMPLEX  = 2'd2;

	typedef struct packed {
		logic lz;
		logic neg;
		logic zero;
	} cls_t;

	typedef struct packed {
		cls_t                          cls;
		logic signed [COEF_WIDTH-1:0]  a;
		logic signed [NB_W-1:0]        nb;
	} tag_t;

	typedef struct packed {
		tag_t            tag;
		logic [DM_W-1:0] dm;
	} item_t;

	typedef struct packed {
		logic [ROOT_WIDTH-1:0] val;
		logic                  ovf;
	} sat_t;

	// Applies the sign to an unsigned quotient and clamps it to the root range.
	function automatic sat_t sat_root(input logic [NUM_W-1:0] q, input logic neg);
		logic signed [EXT_W-1:0] v;
		logic signed [EXT_W-1:0] hi;
		logic signed [EXT_W-1:0] lo;
		sat_t r;
		v  = $signed({{(EXT_W-NUM_W){1'b0}}, q});
		if (neg) begin
			v = -v;
		end
		hi = $signed({{(EXT_W-ROOT_WIDTH+1){1'b0}}, {(ROOT_WIDTH-1){1'b1}}});
		lo = ~hi;
		if (v > hi) begin
			r.val = hi[ROOT_WIDTH-1:0];
			r.ovf = 1'b1;
		end else if (v < lo) begin
			r.val = lo[ROOT_WIDTH-1:0];
			r.ovf = 1'b1;
		end else begin
			r.val = v[ROOT_WIDTH-1:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* design/qrs_front.sv */
`default_nettype none
module qrs_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_a,
	input  wire logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_b,
	input  wire logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_c,
	input  wire logic                                q_full,
	output logic                                     push,
	output qrs_pkg::item_t                           item
);
	import qrs_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic f1, f2, f3;
	logic signed [COEF_WIDTH-1:0]   a_s1, b_s1, a_s2;
	logic signed [2*COEF_WIDTH-1:0] bsq_s1, p_s1;
	logic signed [D_W-1:0]          d_s2;
	logic signed [NB_W-1:0]         nb_s2;
	item_t                          item_s3;
	logic signed [D_W-1:0]          d_abs;

	assign push     = v_s3 && !q_full;
	assign f3       = !v_s3 || push;
	assign f2       = !v_s2 || f3;
	assign f1       = !v_s1 || f2;
	assign in_ready = f1;
	assign item     = item_s3;

	assign d_abs = d_s2[D_W-1] ? -d_s2 : d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (f1) v_s1 <= in_valid;
			if (f2) v_s2 <= v_s1;
			if (f3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (f1) begin
			a_s1   <= coef_a;
			b_s1   <= coef_b;
			bsq_s1 <= coef_b * coef_b;
			p_s1   <= coef_a * coef_c;
		end
		if (f2) begin
			a_s2  <= a_s1;
			d_s2  <= D_W'(bsq_s1) - (D_W'(p_s1) <<< 2);
			nb_s2 <= -(NB_W'(b_s1) <<< FRAC_BITS);
		end
		if (f3) begin
			item_s3.tag.cls.lz   <= (a_s2 == '0);
			item_s3.tag.cls.neg  <= d_s2[D_W-1];
			item_s3.tag.cls.zero <= (d_s2 == '0);
			item_s3.tag.a        <= a_s2;
			item_s3.tag.nb       <= nb_s2;
			item_s3.dm           <= d_abs[DM_W-1:0];
		end
	end
endmodule
`default_nettype wire

/* design/qrs_queue.sv */
`default_nettype none
module qrs_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire qrs_pkg::item_t din,
	output logic                full,
	input  wire logic           pop,
	output qrs_pkg::item_t      dout,
	output logic                empty
);
	import qrs_pkg::*;

	item_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_q, rd_q;
	logic [Q_CNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

/* design/qrs_sqrt.sv */
`default_nettype none
module qrs_sqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_valid,
	input  wire logic [qrs_pkg::RAD_W-1:0] radicand,
	input  wire qrs_pkg::tag_t             in_tag,
	output logic                           out_valid,
	output logic [qrs_pkg::SQ_W-1:0]       root,
	output qrs_pkg::tag_t                  out_tag
);
	import qrs_pkg::*;

	// One result bit per stage, two radicand bits consumed per stage.
	logic              v_s    [SQ_W];
	logic [RM_W-1:0]   rem_s  [SQ_W];
	logic [SQ_W-1:0]   root_s [SQ_W];
	logic [RAD_W-1:0]  rad_s  [SQ_W];
	tag_t              tag_s  [SQ_W];

	for (genvar k = 0; k < SQ_W; k++) begin : g_st
		logic              v_in;
		logic [RM_W-1:0]   rem_in, rem_sh, trial;
		logic [SQ_W-1:0]   root_in;
		logic [RAD_W-1:0]  rad_in;
		tag_t              tag_in;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = radicand;
			assign tag_in  = in_tag;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign tag_in  = tag_s[k-1];
		end

		assign rem_sh = {rem_in[RM_W-3:0], rad_in[RAD_W-1 -: 2]};
		assign trial  = {root_in, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? rem_sh - trial : rem_sh;
				root_s[k] <= {root_in[SQ_W-2:0], ge};
				rad_s[k]  <= rad_in << 2;
				tag_s[k]  <= tag_in;
			end
		end
	end

	assign out_valid = v_s[SQ_W-1];
	assign root      = root_s[SQ_W-1];
	assign out_tag   = tag_s[SQ_W-1];
endmodule
`default_nettype wire

/* design/qrs_div.sv */
`default_nettype none
module qrs_div (
	input  wire logic                                 clk,
	input  wire logic                                 en,
	input  wire logic signed [qrs_pkg::NUM_W-1:0]     num,
	input  wire logic signed [qrs_pkg::COEF_WIDTH-1:0] coef,
	output logic [qrs_pkg::NUM_W-1:0]                 quot,
	output logic                                      neg
);
	import qrs_pkg::*;

	logic [NUM_W-1:0]      m_s0;
	logic [DEN_W-1:0]      d_s0;
	logic                  neg_s0;
	logic [NUM_W-1:0]      num_mag;
	logic [COEF_WIDTH-1:0] coef_mag;

	logic [DR_W-1:0]  rem_s [NUM_W];
	logic [NUM_W-1:0] q_s   [NUM_W];
	logic [NUM_W-1:0] n_s   [NUM_W];
	logic [DEN_W-1:0] d_s   [NUM_W];
	logic             ng_s  [NUM_W];

	assign num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign coef_mag = coef[COEF_WIDTH-1] ? COEF_WIDTH'(-coef) : COEF_WIDTH'(coef);

	// Adding |a| to the dividend rounds the quotient by 2|a| to nearest, halves away.
	always_ff @(posedge clk) begin
		if (en) begin
			m_s0   <= num_mag + NUM_W'(coef_mag);
			d_s0   <= {coef_mag, 1'b0};
			neg_s0 <= num[NUM_W-1] != coef[COEF_WIDTH-1];
		end
	end

	for (genvar k = 0; k < NUM_W; k++) begin : g_st
		logic [DR_W-1:0]  rem_in, rem_sh;
		logic [NUM_W-1:0] q_in, n_in;
		logic [DEN_W-1:0] d_in;
		logic             ng_in, ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign q_in   = '0;
			assign n_in   = m_s0;
			assign d_in   = d_s0;
			assign ng_in  = neg_s0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign q_in   = q_s[k-1];
			assign n_in   = n_s[k-1];
			assign d_in   = d_s[k-1];
			assign ng_in  = ng_s[k-1];
		end

		assign rem_sh = {rem_in[DR_W-2:0], n_in[NUM_W-1]};
		assign ge     = (rem_sh >= {1'b0, d_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? rem_sh - {1'b0, d_in} : rem_sh;
				q_s[k]   <= {q_in[NUM_W-2:0], ge};
				n_s[k]   <= n_in << 1;
				d_s[k]   <= d_in;
				ng_s[k]  <= ng_in;
			end
		end
	end

	assign quot = q_s[NUM_W-1];
	assign neg  = ng_s[NUM_W-1];
endmodule
`default_nettype wire

/* design/qrs_back.sv */
`default_nettype none
module qrs_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_empty,
	input  wire qrs_pkg::item_t                q_item,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [1:0]                         root_kind,
	output logic [qrs_pkg::ROOT_WIDTH-1:0]     first_root,
	output logic [qrs_pkg::ROOT_WIDTH-1:0]     second_root,
	output logic [qrs_pkg::ROOT_WIDTH-1:0]     imag_part,
	output logic                               overflow,
	output logic                               leading_zero
);
	import qrs_pkg::*;

	logic en;
	logic sq_valid;
	logic [SQ_W-1:0] sq_root;
	tag_t sq_tag;

	logic                         v_p;
	logic signed [NUM_W-1:0]      n1_p, n2_p, n3_p;
	logic signed [COEF_WIDTH-1:0] a_p;
	cls_t                         cls_p;

	logic signed [NUM_W-1:0] nb_ext, s_ext;

	logic             v_dl   [DIV_LAT];
	cls_t             cls_dl [DIV_LAT];

	logic [NUM_W-1:0] q1, q2, q3;
	logic             ng1, ng2, ng3;
	sat_t             r1, r2, r3;
	cls_t             cls_o;

	logic                  out_valid_q, lz_q, ovf_q;
	logic [1:0]            kind_q;
	logic [ROOT_WIDTH-1:0] first_q, second_q, imag_q;

	// The whole back pipeline moves only when the output register can take a beat.
	assign en  = !out_valid_q || out_ready;
	assign pop = en && !q_empty;

	qrs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (!q_empty),
		.radicand (RAD_W'(q_item.dm) << (2 * FRAC_BITS)),
		.in_tag   (q_item.tag),
		.out_valid(sq_valid),
		.root     (sq_root),
		.out_tag  (sq_tag)
	);

	assign nb_ext = NUM_W'(sq_tag.nb);
	assign s_ext  = $signed(NUM_W'(sq_root));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= 1'b0;
		end else if (en) begin
			v_p <= sq_valid;
		end
	end

	// Complex pairs divide -b for the real part and the root for the imaginary part.
	always_ff @(posedge clk) begin
		if (en) begin
			n1_p  <= sq_tag.cls.neg ? nb_ext : nb_ext + s_ext;
			n2_p  <= nb_ext - s_ext;
			n3_p  <= s_ext;
			a_p   <= sq_tag.a;
			cls_p <= sq_tag.cls;
		end
	end

	qrs_div u_div1 (.clk(clk), .en(en), .num(n1_p), .coef(a_p), .quot(q1), .neg(ng1));
	qrs_div u_div2 (.clk(clk), .en(en), .num(n2_p), .coef(a_p), .quot(q2), .neg(ng2));
	qrs_div u_div3 (.clk(clk), .en(en), .num(n3_p), .coef(a_p), .quot(q3), .neg(ng3));

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_dl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_dl[k] <= 1'b0;
			end else if (en) begin
				v_dl[k] <= (k == 0) ? v_p : v_dl[(k == 0) ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				cls_dl[k] <= (k == 0) ? cls_p : cls_dl[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign cls_o = cls_dl[DIV_LAT-1];
	assign r1    = sat_root(q1, ng1);
	assign r2    = sat_root(q2, ng2);
	assign r3    = sat_root(q3, ng3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_dl[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (cls_o.lz) begin
				kind_q   <= KIND_TWO_REAL;
				first_q  <= '0;
				second_q <= '0;
				imag_q   <= '0;
				ovf_q    <= 1'b0;
				lz_q     <= 1'b1;
			end else if (cls_o.neg) begin
				kind_q   <= KIND_COMPLEX;
				first_q  <= r1.val;
				second_q <= r1.val;
				imag_q   <= r3.val;
				ovf_q    <= r1.ovf || r3.ovf;
				lz_q     <= 1'b0;
			end else begin
				kind_q   <= cls_o.zero ? KIND_DOUBLE : KIND_TWO_REAL;
				first_q  <= r1.val;
				second_q <= r2.val;
				imag_q   <= '0;
				ovf_q    <= r1.ovf || r2.ovf;
				lz_q     <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign root_kind    = kind_q;
	assign first_root   = first_q;
	assign second_root  = second_q;
	assign imag_part    = imag_q;
	assign overflow     = ovf_q;
	assign leading_zero = lz_q;
endmodule
`default_nettype wire

/* design/quadratic_root_solver_core.sv */
// Throughput: one coefficient triple per cycle while the output is not stalled; the square root
// and the three dividers are pipelined one result bit per stage, so their depth sets the latency
// and not the rate.
// A four-entry queue between the discriminant front end and the root/divide back end
// lets either side stall on its own. Reset is asynchronous, active low, and empties all stages.
`default_nettype none
module quadratic_root_solver_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// coef_a, coef_b, coef_c
	input  wire logic [qrs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// first_root, second_root, imag_part
	output logic [qrs_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
	// root_kind, overflow, leading_zero
	output logic [qrs_pkg::OUT_USER_W-1:0]          m_axis_tuser
);
	import qrs_pkg::*;

	logic  q_full, q_empty, push, pop;
	item_t f_item, q_item;
	logic  [1:0] root_kind;
	logic  [ROOT_WIDTH-1:0] first_root, second_root, imag_part;
	logic  overflow, leading_zero;

	qrs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.coef_a  ($signed(s_axis_tdata[COEF_WIDTH-1:0])),
		.coef_b  ($signed(s_axis_tdata[2*COEF_WIDTH-1:COEF_WIDTH])),
		.coef_c  ($signed(s_axis_tdata[3*COEF_WIDTH-1:2*COEF_WIDTH])),
		.q_full  (q_full),
		.push    (push),
		.item    (f_item)
	);

	qrs_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (f_item),
		.full  (q_full),
		.pop   (pop),
		.dout  (q_item),
		.empty (q_empty)
	);

	qrs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_item      (q_item),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.root_kind   (root_kind),
		.first_root  (first_root),
		.second_root (second_root),
		.imag_part   (imag_part),
		.overflow    (overflow),
		.leading_zero(leading_zero)
	);

	assign m_axis_tdata = OUT_DATA_W'({imag_part, second_root, first_root});
	assign m_axis_tuser = {leading_zero, overflow, root_kind};
endmodule
`default_nettype wire

/* design/qrs_checker.sv */
`default_nettype none
module qrs_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              m_axis_tvalid,
	input wire logic                              m_axis_tready,
	input wire logic [qrs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input wire logic [qrs_pkg::OUT_USER_W-1:0]    m_axis_tuser
);
	import qrs_pkg::*;

	logic [1:0]            kind;
	logic [ROOT_WIDTH-1:0] first_r, second_r, imag_r;

	assign kind     = m_axis_tuser[1:0];
	assign first_r  = m_axis_tdata[ROOT_WIDTH-1:0];
	assign second_r = m_axis_tdata[2*ROOT_WIDTH-1:ROOT_WIDTH];
	assign imag_r   = m_axis_tdata[3*ROOT_WIDTH-1:2*ROOT_WIDTH];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	a_lz: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tdata == '0 && m_axis_tuser[2:0] == '0)
		else $error("zero leading coefficient with nonzero results");

	a_cplx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && kind == KIND_COMPLEX |-> first_r == second_r)
		else $error("complex pair with differing real parts");

	a_real: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && kind != KIND_COMPLEX |-> imag_r == '0)
		else $error("real roots with nonzero imaginary part");

	a_dbl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && kind == KIND_DOUBLE |-> first_r == second_r)
		else $error("double root with differing values");
endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (.*);
`default_nettype wire
